// ===== design/gg_pkg.sv =====
// ----------------------------------------------------------------------------
// gg_pkg: shared types and constants for the gaussian grid map
// Sizes, op codes, register indexes, point type and the tail anchor table.
// ----------------------------------------------------------------------------
package gg_pkg;

  localparam int MAX_POINTS      = 64;
  localparam int IDX_W           = $clog2(MAX_POINTS);
  localparam int CNT_W           = IDX_W + 1;
  localparam int GRID_DIM        = 256;
  localparam int CDF_TABLE_DEPTH = 256;
  localparam int ANCHOR_LAST     = 36;

  // squared distance and root widths (17 bit magnitudes per axis)
  localparam int SQ_W   = 36;
  localparam int ROOT_W = SQ_W / 2;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [1:0] CFG_SPREAD    = 2'd1;
  localparam logic [1:0] CFG_MARGIN    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRID,
    ST_SCAN,
    ST_ROOT,
    ST_TAIL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  // control for the nearest-distance unit
  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

  // 1 - Phi(z) at steps of 1/8, Q0.16
  function automatic logic [15:0] tail_anchor(input logic [5:0] k);
    logic [15:0] v;
    case (k)
      6'd0:  v = 16'd32768;
      6'd1:  v = 16'd29508;
      6'd2:  v = 16'd26299;
      6'd3:  v = 16'd23189;
      6'd4:  v = 16'd20220;
      6'd5:  v = 16'd17432;
      6'd6:  v = 16'd14852;
      6'd7:  v = 16'd12503;
      6'd8:  v = 16'd10398;
      6'd9:  v = 16'd8539;
      6'd10: v = 16'd6924;
      6'd11: v = 16'd5542;
      6'd12: v = 16'd4378;
      6'd13: v = 16'd3413;
      6'd14: v = 16'd2625;
      6'd15: v = 16'd1992;
      6'd16: v = 16'd1491;
      6'd17: v = 16'd1101;
      6'd18: v = 16'd801;
      6'd19: v = 16'd575;
      6'd20: v = 16'd407;
      6'd21: v = 16'd284;
      6'd22: v = 16'd195;
      6'd23: v = 16'd132;
      6'd24: v = 16'd88;
      6'd25: v = 16'd58;
      6'd26: v = 16'd38;
      6'd27: v = 16'd24;
      6'd28: v = 16'd15;
      6'd29: v = 16'd9;
      6'd30: v = 16'd6;
      6'd31: v = 16'd3;
      6'd32: v = 16'd2;
      6'd33: v = 16'd1;
      6'd34: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/gg_cell.sv =====
// ----------------------------------------------------------------------------
// gg_cell: one obstacle cell of the storage chain
// Holds one point and passes it to the next cell when the chain shifts.
// ----------------------------------------------------------------------------
module gg_cell
  import gg_pkg::*;
(
  input  logic   clk,
  input  logic   shift,
  input  point_t din,
  output point_t dout
);

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

// ===== design/gg_nearest.sv =====
// ----------------------------------------------------------------------------
// gg_nearest: nearest obstacle search
// Three-stage pipe: axis distances, squares, running minimum.
// ----------------------------------------------------------------------------
module gg_nearest
  import gg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  scan_ctl_t          ctl,
  input  point_t             pt,
  input  logic signed [24:0] cx,
  input  logic signed [24:0] cy,
  output logic [SQ_W-1:0]    best
);

  logic signed [25:0] dx, dy;
  logic [16:0]        ax, ay;
  logic               v1, v2, have;
  logic [33:0]        sqx, sqy;
  logic [SQ_W-1:0]    sum;

  // axis offsets from the cell origin
  always_comb begin
    dx = $signed({{10{pt.x[15]}}, pt.x}) - $signed({cx[24], cx});
    dy = $signed({{10{pt.y[15]}}, pt.y}) - $signed({cy[24], cy});
    sum = {2'b00, sqx} + {2'b00, sqy};
  end

  // stage 1: magnitudes
  always_ff @(posedge clk) begin
    ax <= dx[25] ? 17'(-dx) : dx[16:0];
    ay <= dy[25] ? 17'(-dy) : dy[16:0];
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    sqx <= ax * ax;
    sqy <= ay * ay;
  end

  // stage 3: running minimum
  always_ff @(posedge clk) begin
    if (v2 && (!have || sum < best)) begin
      best <= sum;
    end
  end

  // valid flags through the pipe
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      have <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
      if (v2) begin
        have <= 1'b1;
      end
    end
  end

endmodule

// ===== design/gg_root.sv =====
// ----------------------------------------------------------------------------
// gg_root: integer square root
// Floor root of the squared distance, one result bit per cycle.
// ----------------------------------------------------------------------------
module gg_root
  import gg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [SQ_W-1:0]   v;
  logic [ROOT_W+1:0] rem, rem2, trial;
  logic [4:0]        cnt;
  logic              busy;

  // next pair of bits against the trial value
  always_comb begin
    rem2  = {rem[ROOT_W-1:0], v[SQ_W-1 -: 2]};
    trial = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v <= {v[SQ_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem  <= rem2 - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem2;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/gg_tail.sv =====
// ----------------------------------------------------------------------------
// gg_tail: gaussian tail lookup
// Bin index by bit-serial division, then linear interpolation of the anchors.
// ----------------------------------------------------------------------------
module gg_tail
  import gg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ROOT_W-1:0] distance,
  input  logic [14:0]       spread,
  output logic              done,
  output logic [15:0]       prob
);

  logic [14:0] sp;
  logic [18:0] dvs, two_d, rem;
  logic [19:0] rem2;
  logic [7:0]  q;
  logic        sat;
  logic [13:0] pos;
  logic [15:0] hi, lo, hi_r, diff_r;
  logic [7:0]  frac_r;
  logic [23:0] prod;
  logic [3:0]  cnt;
  logic        busy;

  always_comb begin
    sp    = (spread == 15'd0) ? 15'd1 : spread;
    dvs   = 19'(sp * 4'd9);
    two_d = {distance, 1'b0};
    rem2  = {rem, 1'b0};
    pos   = 14'(q * 6'(ANCHOR_LAST));
    hi    = tail_anchor(pos[13:8]);
    lo    = tail_anchor(6'(pos[13:8] + 6'd1));
    prod  = diff_r * frac_r;
  end

  // datapath: divide steps, table read, interpolation
  always_ff @(posedge clk) begin
    if (start) begin
      sat <= (two_d >= dvs);
      rem <= two_d;
      q   <= '0;
    end else if (busy) begin
      if (cnt < 4'd8) begin
        if (rem2 >= {1'b0, dvs}) begin
          rem <= 19'(rem2 - {1'b0, dvs});
          q   <= {q[6:0], 1'b1};
        end else begin
          rem <= rem2[18:0];
          q   <= {q[6:0], 1'b0};
        end
      end else if (cnt == 4'd8) begin
        hi_r   <= hi;
        diff_r <= hi - lo;
        frac_r <= pos[7:0];
      end else begin
        prob <= sat ? 16'd0 : 16'(hi_r - 16'((prod + 24'd128) >> 8));
      end
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd9) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/gaussian_grid_map.sv =====
// ----------------------------------------------------------------------------
// Gaussian likelihood grid map, top level
// Obstacle chain, bounds tracking and the query sequencer.
// ----------------------------------------------------------------------------
// Clear and add beats are taken in idle and keep the sequencer there, so they
// can follow back to back. A query that lands on the grid runs the grid size
// division, one full turn of the 64-cell obstacle chain through the distance
// pipe, the square root and the tail lookup, then loads the output register.
// An off-grid or empty-map query skips the search and goes straight to the
// output load. The load waits while the previous result is still held. The
// obstacle chain turns a full lap on every query that lands on the grid, so
// it is back in order afterwards. A result waits in the output register
// while the next beat is taken. There is no clearing pass after reset.
module gaussian_grid_map
  import gg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // obs_x, obs_y, cell_ix, cell_iy
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // probability, grid_width, grid_height, zero pad
  output logic [1:0]  m_tuser    // off_grid, map_empty
);

  state_t state, state_next;

  logic [14:0] cell_size, spread, margin;
  logic [CNT_W-1:0] count;
  logic signed [15:0] bmin_x, bmax_x, bmin_y, bmax_y;

  logic [1:0]  op;
  point_t      new_pt;
  logic        accept, add_ok;
  logic [6:0]  cnt;
  logic [7:0]  ix, iy;

  // grid size division
  logic [14:0] cs;
  logic [15:0] span_x, span_y;
  logic [14:0] rem_x, rem_y;
  logic [15:0] rem2_x, rem2_y;
  logic [7:0]  q_x, q_y;
  logic        sat_x, sat_y;
  logic [8:0]  gw_c, gh_c, gw, gh;
  logic        off, empty;
  logic signed [24:0] cx, cy;

  // bounds of a new point
  logic signed [18:0] ox2, oy2, m19;
  logic signed [15:0] lx, hx, ly, hy;

  // chain
  point_t    chain [MAX_POINTS];
  point_t    head_in;
  logic      shift;
  logic [IDX_W-1:0] orig_idx;
  scan_ctl_t scan_ctl;
  logic [SQ_W-1:0] best;

  logic              root_start, root_done, tail_start, tail_done;
  logic [ROOT_W-1:0] root;
  logic [15:0]       tail_prob, prob;
  logic              out_load;

  // truncating divide by 512
  function automatic logic signed [15:0] div512(input logic signed [18:0] v);
    logic signed [18:0] adj;
    adj = v + (v[18] ? 19'sd511 : 19'sd0);
    return {{6{adj[18]}}, adj[18:9]};
  endfunction

  assign op       = s_tuser;
  // x sits in the upper half of the point
  assign new_pt   = {s_tdata[15:0], s_tdata[31:16]};
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign add_ok   = accept && (op == OP_ADD) && (count < CNT_W'(MAX_POINTS));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= 15'd128;
      spread    <= 15'd1280;
      margin    <= 15'd2560;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE: cell_size <= cfg_data;
        CFG_SPREAD:    spread    <= cfg_data;
        CFG_MARGIN:    margin    <= cfg_data;
        default: ;
      endcase
    end
  end

  // widened bounds of the incoming point
  always_comb begin
    ox2 = {new_pt.x[15], new_pt.x[15], new_pt.x, 1'b0};
    oy2 = {new_pt.y[15], new_pt.y[15], new_pt.y, 1'b0};
    m19 = {4'b0000, margin};
    lx  = div512(ox2 - m19);
    hx  = div512(ox2 + m19);
    ly  = div512(oy2 - m19);
    hy  = div512(oy2 + m19);
  end

  // obstacle count and bounds
  always_ff @(posedge clk) begin
    if (rst || (accept && op == OP_CLEAR)) begin
      count  <= '0;
      bmin_x <= '0;
      bmax_x <= '0;
      bmin_y <= '0;
      bmax_y <= '0;
    end else if (add_ok) begin
      count <= count + CNT_W'(1);
      if (count == '0) begin
        bmin_x <= lx;
        bmax_x <= hx;
        bmin_y <= ly;
        bmax_y <= hy;
      end else begin
        if (lx < bmin_x) bmin_x <= lx;
        if (hx > bmax_x) bmax_x <= hx;
        if (ly < bmin_y) bmin_y <= ly;
        if (hy > bmax_y) bmax_y <= hy;
      end
    end
  end

  // obstacle chain: new points enter at the head, on-grid queries rotate a full lap
  assign head_in  = add_ok ? new_pt : chain[MAX_POINTS-1];
  assign orig_idx = ~cnt[IDX_W-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_POINTS; gi++) begin : g_chain
      if (gi == 0) begin : g_head
        gg_cell u_cell (.clk(clk), .shift(shift), .din(head_in), .dout(chain[gi]));
      end else begin : g_body
        gg_cell u_cell (.clk(clk), .shift(shift), .din(chain[gi-1]), .dout(chain[gi]));
      end
    end
  endgenerate

  // grid size terms
  always_comb begin
    cs     = (cell_size == 15'd0) ? 15'd1 : cell_size;
    span_x = 16'(bmax_x - bmin_x);
    span_y = 16'(bmax_y - bmin_y);
    rem2_x = {rem_x, 1'b0};
    rem2_y = {rem_y, 1'b0};
    gw_c   = sat_x ? 9'(GRID_DIM) : {1'b0, q_x};
    gh_c   = sat_y ? 9'(GRID_DIM) : {1'b0, q_y};
    empty  = (count == '0);
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    shift      = add_ok;
    scan_ctl   = '0;
    root_start = 1'b0;
    tail_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && op == OP_QUERY) state_next = ST_GRID;
      end
      ST_GRID: begin
        if (cnt == 7'd8) begin
          scan_ctl.clear = 1'b1;
          if (empty || {1'b0, ix} >= gw_c || {1'b0, iy} >= gh_c) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        shift          = (cnt < 7'(MAX_POINTS));
        scan_ctl.valid = shift && ({1'b0, orig_idx} < count);
        if (cnt == 7'(MAX_POINTS + 2)) begin
          root_start = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          tail_start = 1'b1;
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (tail_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state_next != state) begin
      cnt <= '0;
    end else if (state == ST_GRID || state == ST_SCAN) begin
      cnt <= cnt + 7'd1;
    end
  end

  // query datapath: capture, grid division, origin, result
  always_ff @(posedge clk) begin
    if (accept) begin
      ix    <= s_tdata[39:32];
      iy    <= s_tdata[47:40];
      sat_x <= (span_x >= {1'b0, cs});
      sat_y <= (span_y >= {1'b0, cs});
      rem_x <= span_x[14:0];
      rem_y <= span_y[14:0];
      q_x   <= '0;
      q_y   <= '0;
    end else if (state == ST_GRID) begin
      if (cnt < 7'd8) begin
        if (rem2_x >= {1'b0, cs}) begin
          rem_x <= 15'(rem2_x - {1'b0, cs});
          q_x   <= {q_x[6:0], 1'b1};
        end else begin
          rem_x <= rem2_x[14:0];
          q_x   <= {q_x[6:0], 1'b0};
        end
        if (rem2_y >= {1'b0, cs}) begin
          rem_y <= 15'(rem2_y - {1'b0, cs});
          q_y   <= {q_y[6:0], 1'b1};
        end else begin
          rem_y <= rem2_y[14:0];
          q_y   <= {q_y[6:0], 1'b0};
        end
      end else begin
        gw   <= gw_c;
        gh   <= gh_c;
        off  <= empty || {1'b0, ix} >= gw_c || {1'b0, iy} >= gh_c;
        prob <= 16'd0;
        // origin uses the raw cell size
        cx   <= $signed({2'b00, 23'(ix * cell_size)}) + $signed({bmin_x[15], bmin_x, 8'h00});
        cy   <= $signed({2'b00, 23'(iy * cell_size)}) + $signed({bmin_y[15], bmin_y, 8'h00});
      end
    end else if (state == ST_TAIL && tail_done) begin
      prob <= tail_prob;
    end
  end

  gg_nearest u_nearest (
    .clk  (clk),
    .rst  (rst),
    .ctl  (scan_ctl),
    .pt   (chain[MAX_POINTS-1]),
    .cx   (cx),
    .cy   (cy),
    .best (best)
  );

  gg_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (best),
    .done  (root_done),
    .root  (root)
  );

  gg_tail u_tail (
    .clk      (clk),
    .rst      (rst),
    .start    (tail_start),
    .distance (root),
    .spread   (spread),
    .done     (tail_done),
    .prob     (tail_prob)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b000000, gh, gw, prob};
      m_tuser <= {empty, off};
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: gaussian grid map testbench
// Drives clear, add and query beats with random idling on both streams,
// predicts every query result in a scoreboard and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top
  import gg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] prob;
    logic [8:0]  gw;
    logic [8:0]  gh;
    logic        off;
    logic        empty;
  } grid_result_t;

  // grid map predictor plus queue of pending query results
  class grid_scoreboard;
    int unsigned cell_size, spread, margin;
    int px[MAX_POINTS];
    int py[MAX_POINTS];
    int unsigned count;
    int bmin_x, bmax_x, bmin_y, bmax_y;
    grid_result_t pending[$];
    int errors;

    function void clear_map();
      count = 0;
      bmin_x = 0; bmax_x = 0; bmin_y = 0; bmax_y = 0;
    endfunction

    function void reset_state();
      cell_size = 128; spread = 1280; margin = 2560;
      clear_map();
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] val);
      if (idx == CFG_CELL_SIZE) cell_size = val;
      else if (idx == CFG_SPREAD) spread = val;
      else if (idx == CFG_MARGIN) margin = val;
    endfunction

    function int unsigned extent(int lo, int hi);
      longint unsigned n;
      longint span;
      span = longint'(hi) - longint'(lo);
      if (span <= 0) return 0;
      n = (span * 256) / (cell_size ? cell_size : 1);
      return (n > GRID_DIM) ? GRID_DIM : n;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function int unsigned tail_prob(longint unsigned d);
      longint unsigned sp, bin, pos, k, r, hi, lo;
      sp = spread ? spread : 1;
      bin = (d * 2 * CDF_TABLE_DEPTH) / (sp * 9);
      if (bin >= CDF_TABLE_DEPTH) return 0;
      pos = bin * ANCHOR_LAST;
      k = pos / CDF_TABLE_DEPTH;
      r = pos % CDF_TABLE_DEPTH;
      if (k >= ANCHOR_LAST) return tail_anchor(6'(ANCHOR_LAST));
      hi = tail_anchor(6'(k));
      lo = tail_anchor(6'(k + 1));
      return hi - ((hi - lo) * r + CDF_TABLE_DEPTH / 2) / CDF_TABLE_DEPTH;
    endfunction

    // note an accepted input beat
    function void note_input(logic [1:0] op, logic [47:0] data);
      int ox, oy, m, lx, hx, ly, hy;
      int unsigned ix, iy;
      longint cx, cy, dx, dy;
      longint unsigned best, sq;
      grid_result_t res;
      ox = int'($signed(data[15:0]));
      oy = int'($signed(data[31:16]));
      ix = data[39:32];
      iy = data[47:40];
      if (op == OP_CLEAR) begin
        clear_map();
      end else if (op == OP_ADD) begin
        m = margin;
        lx = (2 * ox - m) / 512; hx = (2 * ox + m) / 512;
        ly = (2 * oy - m) / 512; hy = (2 * oy + m) / 512;
        if (count < MAX_POINTS) begin
          if (count == 0) begin
            bmin_x = lx; bmax_x = hx; bmin_y = ly; bmax_y = hy;
          end else begin
            if (lx < bmin_x) bmin_x = lx;
            if (hx > bmax_x) bmax_x = hx;
            if (ly < bmin_y) bmin_y = ly;
            if (hy > bmax_y) bmax_y = hy;
          end
          px[count] = ox; py[count] = oy;
          count++;
        end
      end else if (op == OP_QUERY) begin
        res.gw = extent(bmin_x, bmax_x);
        res.gh = extent(bmin_y, bmax_y);
        res.empty = (count == 0);
        res.off = res.empty || ix >= res.gw || iy >= res.gh;
        res.prob = 0;
        if (!res.off) begin
          cx = longint'(ix) * cell_size + longint'(bmin_x) * 256;
          cy = longint'(iy) * cell_size + longint'(bmin_y) * 256;
          best = 0;
          for (int i = 0; i < count; i++) begin
            dx = px[i] - cx; dy = py[i] - cy;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            sq = dx * dx + dy * dy;
            if (i == 0 || sq < best) best = sq;
          end
          res.prob = tail_prob(root_floor(best));
        end
        pending = {pending, res};
      end
    endfunction

    // compare an output beat with the oldest prediction
    function void check_result(logic [39:0] data, logic [1:0] user);
      grid_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h/%h", data, user);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.prob) begin
        $error("probability exp %0d got %0d", e.prob, data[15:0]); errors++;
      end
      if (data[24:16] !== e.gw) begin
        $error("grid_width exp %0d got %0d", e.gw, data[24:16]); errors++;
      end
      if (data[33:25] !== e.gh) begin
        $error("grid_height exp %0d got %0d", e.gh, data[33:25]); errors++;
      end
      if (user[0] !== e.off) begin
        $error("off_grid exp %0d got %0d", e.off, user[0]); errors++;
      end
      if (user[1] !== e.empty) begin
        $error("map_empty exp %0d got %0d", e.empty, user[1]); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;
  logic        s_tvalid, s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;   // op
  logic        m_tvalid, m_tready;
  logic [39:0] m_tdata;   // probability, grid_width, grid_height, pad
  logic [1:0]  m_tuser;   // off_grid, map_empty

  grid_scoreboard board;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  gaussian_grid_map uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    board = new();
    board.reset_state();
  end

  // receiver side: random stall, check every result beat
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[gaussian_grid_map] ERROR");
        $finish;
      end
    end
  end

  // valid stays high across back-to-back beats, drops only while idling or draining
  task automatic send_beat(logic [1:0] op, logic [47:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(op, data);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
  endtask

  function automatic logic [47:0] pack_pt(int x, int y);
    return {16'd0, 16'(y), 16'(x)};
  endfunction

  function automatic logic [47:0] pack_cell(int ix, int iy);
    return {8'(iy), 8'(ix), 32'(0)};
  endfunction

  // one random load-and-query phase
  task automatic random_phase(int n);
    int npts, spanq;
    for (int k = 0; k < n; ) begin
      send_beat(OP_CLEAR, 48'($urandom()) << 16 | 48'($urandom()));
      k++;
      npts = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      spanq = ($urandom_range(3) == 0) ? 32767 : $urandom_range(64, 4000);
      for (int i = 0; i < npts; i++) begin
        send_beat(OP_ADD, {$urandom_range(65535) > 0 ? 16'($urandom()) : 16'd0,
                           16'($urandom_range(2 * spanq) - spanq),
                           16'($urandom_range(2 * spanq) - spanq)});
        k++;
      end
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(9) == 0)
          send_beat(2'($urandom_range(3)), {$urandom(), 16'($urandom())});
        else
          send_beat(OP_QUERY, {8'($urandom_range(40)), 8'($urandom_range(40)),
                               $urandom()});
        k++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = CFG_CELL_SIZE; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_CLEAR;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty map, extremes, store full, unused op
    send_beat(OP_QUERY, pack_cell(0, 0));
    send_beat(2'd3, 48'hFFFF_FFFF_FFFF);
    send_beat(OP_ADD, pack_pt(-32768, 32767));
    send_beat(OP_ADD, pack_pt(32767, -32768));
    send_beat(OP_QUERY, pack_cell(0, 0));
    send_beat(OP_QUERY, pack_cell(255, 255));
    send_beat(OP_QUERY, pack_cell(100, 3));
    send_beat(OP_CLEAR, '0);
    send_beat(OP_QUERY, pack_cell(1, 1));
    send_beat(OP_ADD, pack_pt(0, 0));
    send_beat(OP_QUERY, pack_cell(0, 0));
    send_beat(OP_QUERY, pack_cell(1, 0));
    write_reg(CFG_MARGIN, 15'd0);
    send_beat(OP_ADD, pack_pt(1000, -700));
    for (int i = 0; i < 64; i++) send_beat(OP_ADD, pack_pt(i * 300, -i * 200));
    send_beat(OP_QUERY, pack_cell(2, 2));
    write_reg(CFG_CELL_SIZE, 15'd32767);
    write_reg(CFG_SPREAD, 15'd1);
    send_beat(OP_QUERY, pack_cell(0, 0));
    write_reg(CFG_CELL_SIZE, 15'd1);
    write_reg(CFG_SPREAD, 15'd32767);
    write_reg(CFG_MARGIN, 15'd32767);
    send_beat(OP_QUERY, pack_cell(200, 7));

    // random phases under three idling profiles and several settings
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 26 : (p < 4) ? 78 : 0;
      recv_idle_pct = (p < 2) ? 78 : (p < 4) ? 26 : 0;
      write_reg(CFG_CELL_SIZE, (p == 5) ? 15'd1 : 15'($urandom_range(16, 512)));
      write_reg(CFG_SPREAD, (p == 4) ? 15'd32767 : 15'($urandom_range(1, 3000)));
      write_reg(CFG_MARGIN, (p == 3) ? 15'd0 : 15'($urandom_range(32767)));
      random_phase(170);
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[gaussian_grid_map] OK");
    else
      $display("[gaussian_grid_map] ERROR");
    $finish;
  end
endmodule
